@@ rtl/hcc_pkg.sv @@
// Shared constants for the HSV color complement pipeline.
package hcc_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int HUE_STEP_BITS_DEF = 8;
  localparam int IO_BITS           = 8;

  // Hue sector base, counted in pairs of sectors
  localparam logic [1:0] BASE_RED   = 2'd0;
  localparam logic [1:0] BASE_GREEN = 2'd1;
  localparam logic [1:0] BASE_BLUE  = 2'd2;

endpackage

@@ rtl/hcc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module hcc_div import hcc_pkg::*; #(
  parameter int NW = 2 * CHANNEL_BITS_DEF,
  parameter int DW = CHANNEL_BITS_DEF,
  parameter int QW = CHANNEL_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [W-1:0]  rin;
    logic [W-1:0]  dsh;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic          ge;

    if (i == 0) begin : g_first
      assign rin = W'(num_i);
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign din = den_r[i-1];
      assign qin = quo_r[i-1];
    end

    assign dsh = W'(din) << (QW - 1 - i);
    assign ge  = (rin >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= {qin[QW-2:0], ge};
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? (rin - dsh) : rin;
          den_r[i] <= din;
        end
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

@@ rtl/hsv_color_complement.sv @@
// Top level: RGB to HSV, complement, HSV back to RGB, fully pipelined.
//
//  channel | direction | tdata fields (low bit first)       | tuser/tlast
//  in_     | slave     | red_in, green_in, blue_in (8 each)  | none
//  out_    | master    | red_out, green_out, blue_out        | none
//
// One transaction per cycle sustained while out_tready is high. From the accepting
// edge to out_tvalid a pixel passes the min/max register, one register per
// quotient bit of the two parallel dividers, then the hue, product and output
// stages. Reset clears valid bits only.
// All stages advance together whenever the output register is empty or taken.
module hsv_color_complement import hcc_pkg::*; #(
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int HUE_STEP_BITS = HUE_STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3*IO_BITS-1:0] in_tdata,   // red_in, green_in, blue_in
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*IO_BITS-1:0] out_tdata   // red_out, green_out, blue_out
);

  localparam int C  = CHANNEL_BITS;
  localparam int H  = HUE_STEP_BITS;
  localparam int HW = H + 3;
  localparam int HX = H + 4;
  localparam int QD = (C > H + 1) ? C : H + 1;
  localparam logic [C-1:0]   CH_FULL   = {C{1'b1}};
  localparam logic [HX-1:0]  HUE_RANGE = HX'(6) << H;
  localparam logic [HX-1:0]  HUE_HALF  = HX'(3) << H;
  localparam logic [C+H-1:0] K_FULL    = (C+H)'(CH_FULL) << H;

  function automatic logic [C-1:0] div_full(input logic [2*C-1:0] x);
    logic [C-1:0] qe;
    logic [C:0]   rm;
    qe = x[2*C-1:C];
    rm = (C+1)'(x[C-1:0]) + (C+1)'(qe);
    return (rm >= (C+1)'(CH_FULL)) ? qe + C'(1) : qe;
  endfunction

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: max, min, hue branch
  logic [C-1:0] r_in, g_in, b_in, mx, mn, dl, pos, neg, diff;
  logic [1:0]   base;

  assign r_in = C'(in_tdata[IO_BITS-1:0]);
  assign g_in = C'(in_tdata[2*IO_BITS-1:IO_BITS]);
  assign b_in = C'(in_tdata[3*IO_BITS-1:2*IO_BITS]);

  always_comb begin
    mx = r_in;
    mn = r_in;
    if (g_in > mx) mx = g_in;
    if (b_in > mx) mx = b_in;
    if (g_in < mn) mn = g_in;
    if (b_in < mn) mn = b_in;
    dl = mx - mn;
    priority if (r_in == mx) begin
      base = BASE_RED;   pos = g_in; neg = b_in;
    end else if (g_in == mx) begin
      base = BASE_GREEN; pos = b_in; neg = r_in;
    end else begin
      base = BASE_BLUE;  pos = r_in; neg = g_in;
    end
    diff = (pos >= neg) ? pos - neg : neg - pos;
  end

  logic           v1_r;
  logic [2*C-1:0] snum1_r;
  logic [C+H-1:0] fnum1_r;
  logic [C-1:0]   mx1_r, dl1_r;
  logic [1:0]     base1_r;
  logic           neg1_r, mz1_r, dz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snum1_r <= {dl, C'(0)} - (2*C)'(dl);
      fnum1_r <= {diff, H'(0)};
      mx1_r   <= mx;
      dl1_r   <= dl;
      base1_r <= base;
      neg1_r  <= (pos < neg);
      mz1_r   <= (mx == '0);
      dz1_r   <= (dl == '0);
    end
  end

  // dividers: saturation and hue fraction
  logic [QD-1:0] squo, fquo;

  hcc_div #(.NW(2*C), .DW(C), .QW(QD)) u_sdiv (
    .clk(clk), .en(en), .num_i(snum1_r), .den_i(mx1_r), .quo_o(squo)
  );
  hcc_div #(.NW(C+H), .DW(C), .QW(QD)) u_fdiv (
    .clk(clk), .en(en), .num_i(fnum1_r), .den_i(dl1_r), .quo_o(fquo)
  );

  logic         vd_r    [QD];
  logic [C-1:0] mxd_r   [QD];
  logic [1:0]   based_r [QD];
  logic         negd_r  [QD];
  logic         mzd_r   [QD];
  logic         dzd_r   [QD];

  for (genvar i = 0; i < QD; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[i] <= 1'b0;
      end else if (en) begin
        vd_r[i] <= (i == 0) ? v1_r : vd_r[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          mxd_r[i]   <= mx1_r;
          based_r[i] <= base1_r;
          negd_r[i]  <= neg1_r;
          mzd_r[i]   <= mz1_r;
          dzd_r[i]   <= dz1_r;
        end else begin
          mxd_r[i]   <= mxd_r[(i == 0) ? 0 : i-1];
          based_r[i] <= based_r[(i == 0) ? 0 : i-1];
          negd_r[i]  <= negd_r[(i == 0) ? 0 : i-1];
          mzd_r[i]   <= mzd_r[(i == 0) ? 0 : i-1];
          dzd_r[i]   <= dzd_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // stage A: hue assembly and complement
  logic [C-1:0]  sat;
  logic [HX-1:0] frac, hbase, hp, hn, hh, h2;
  logic [C-1:0]  v2;

  always_comb begin
    sat   = mzd_r[QD-1] ? '0 : C'(squo);
    frac  = dzd_r[QD-1] ? '0 : HX'(fquo);
    hbase = HX'(based_r[QD-1]) << (H + 1);
    hp    = hbase + frac;
    hn    = hbase + HUE_RANGE - frac;
    if (hn >= HUE_RANGE) hn = hn - HUE_RANGE;
    hh    = negd_r[QD-1] ? hn : hp;
    if (sat[C-1]) begin
      h2 = hh + HUE_HALF;
      if (h2 >= HUE_RANGE) h2 = h2 - HUE_RANGE;
      v2 = mxd_r[QD-1];
    end else begin
      h2 = hh;
      v2 = mxd_r[QD-1][C-1] ? '0 : CH_FULL;
    end
  end

  logic          va_r;
  logic [C-1:0]  sa_r, vala_r;
  logic [HW-1:0] ha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vd_r[QD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r   <= sat;
      vala_r <= v2;
      ha_r   <= HW'(h2);
    end
  end

  // stage B: s * f
  logic           vb_r;
  logic [C-1:0]   sb_r, valb_r;
  logic [2:0]     secb_r;
  logic [C+H-1:0] psb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r   <= sa_r;
      valb_r <= vala_r;
      secb_r <= ha_r[HW-1:H];
      psb_r  <= (C+H)'(sa_r) * (C+H)'(ha_r[H-1:0]);
    end
  end

  // stage C: value products
  logic [C+H-1:0] tq, tt;
  assign tq = K_FULL - psb_r;
  assign tt = K_FULL - ({sb_r, H'(0)} - psb_r);

  logic             vc_r, szc_r;
  logic [C-1:0]     valc_r;
  logic [2:0]       secc_r;
  logic [2*C-1:0]   mpc_r;
  logic [2*C+H-1:0] mqc_r, mtc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      szc_r  <= (sb_r == '0);
      valc_r <= valb_r;
      secc_r <= secb_r;
      mpc_r  <= (2*C)'(valb_r) * (2*C)'(CH_FULL - sb_r);
      mqc_r  <= (2*C+H)'(valb_r) * (2*C+H)'(tq);
      mtc_r  <= (2*C+H)'(valb_r) * (2*C+H)'(tt);
    end
  end

  // stage D: scale down, pick per sector, output register
  logic [C-1:0] pp, qq, tv, ro, go, bo;

  always_comb begin
    pp = div_full(mpc_r);
    qq = div_full(mqc_r[2*C+H-1:H]);
    tv = div_full(mtc_r[2*C+H-1:H]);
    if (szc_r) begin
      ro = valc_r; go = valc_r; bo = valc_r;
    end else begin
      unique case (secc_r)
        3'd0:    begin ro = valc_r; go = tv;     bo = pp;     end
        3'd1:    begin ro = qq;     go = valc_r; bo = pp;     end
        3'd2:    begin ro = pp;     go = valc_r; bo = tv;     end
        3'd3:    begin ro = pp;     go = qq;     bo = valc_r; end
        3'd4:    begin ro = tv;     go = pp;     bo = valc_r; end
        default: begin ro = valc_r; go = pp;     bo = qq;     end
      endcase
    end
  end

  logic                 out_valid_r;
  logic [3*IO_BITS-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {IO_BITS'(bo), IO_BITS'(go), IO_BITS'(ro)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (HX'(ha_r) < HUE_RANGE))
    else $error("hue out of range");

  a_value_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && !sa_r[C-1]) |-> (vala_r == CH_FULL || vala_r == '0))
    else $error("unsaturated value not flipped to an extreme");

  a_grey_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && en && szc_r) |=>
      (out_tdata[IO_BITS-1:0] == out_tdata[2*IO_BITS-1:IO_BITS] &&
       out_tdata[2*IO_BITS-1:IO_BITS] == out_tdata[3*IO_BITS-1:2*IO_BITS]))
    else $error("grey pixel with unequal channels");

endmodule

@@ test/hsv_color_complement_tb.sv @@
// Self-checking testbench for hsv_color_complement: random and corner pixels, predicted complements.
`timescale 1ns / 1ps

module hsv_color_complement_tb;
  import hcc_pkg::*;

  localparam int FULL  = 255;
  localparam int STEP  = 256;
  localparam int RANGE = 6 * STEP;
  localparam int LATENCY = 13;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [3*IO_BITS-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [3*IO_BITS-1:0] out_tdata;

  pixel_t pending_pixels[$];
  pixel_t complement_q[$];
  int errors;
  int sent;
  int received;
  int burst_left;
  int gap_left;
  int hold_cycles;
  int stall_mode;
  bit sender_pause;

  hsv_color_complement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic pixel_t complement_of(pixel_t px);
    longint r, g, b, mx, mn, delta, s, v, h, base, pos, neg, sec, f, k, p, q, t;
    pixel_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    v = mx;
    s = 0;
    h = 0;
    if (mx != 0) begin
      s = delta * FULL / mx;
      if (delta != 0) begin
        if (r == mx) begin
          base = 0; pos = g; neg = b;
        end else if (g == mx) begin
          base = 2 * STEP; pos = b; neg = r;
        end else begin
          base = 4 * STEP; pos = r; neg = g;
        end
        if (pos >= neg) h = base + (pos - neg) * STEP / delta;
        else h = (base + RANGE - (neg - pos) * STEP / delta) % RANGE;
      end
    end
    if (2 * s > FULL) h = (h + 3 * STEP) % RANGE;
    else v = (2 * v < FULL + 1) ? FULL : 0;
    if (s == 0) begin
      res.red = v[7:0]; res.green = v[7:0]; res.blue = v[7:0];
    end else begin
      sec = h / STEP;
      f = h % STEP;
      k = FULL * STEP;
      p = v * (FULL - s) / FULL;
      q = v * (k - s * f) / k;
      t = v * (k - s * (STEP - f)) / k;
      case (sec)
        0: begin res.red = v[7:0]; res.green = t[7:0]; res.blue = p[7:0]; end
        1: begin res.red = q[7:0]; res.green = v[7:0]; res.blue = p[7:0]; end
        2: begin res.red = p[7:0]; res.green = v[7:0]; res.blue = t[7:0]; end
        3: begin res.red = p[7:0]; res.green = q[7:0]; res.blue = v[7:0]; end
        4: begin res.red = t[7:0]; res.green = p[7:0]; res.blue = v[7:0]; end
        default: begin res.red = v[7:0]; res.green = p[7:0]; res.blue = q[7:0]; end
      endcase
    end
    return res;
  endfunction

  function automatic pixel_t mk(int r, int g, int b);
    pixel_t px;
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    return px;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[hsv_color_complement] ERROR");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) sent <= sent + 1;
      if (in_tvalid && !in_tready) begin
        // hold current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (sender_pause || pending_pixels.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= pending_pixels.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (in_tvalid && in_tready) complement_q.push_back(complement_of(in_tdata));
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk) begin
    pixel_t exp_px;
    pixel_t act_px;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        act_px = out_tdata;
        received <= received + 1;
        if (complement_q.size() == 0) begin
          $error("result with no expected transaction: %h", out_tdata);
          errors++;
        end else begin
          exp_px = complement_q.pop_front();
          if (act_px.red !== exp_px.red) begin
            $error("red_out expected %0d actual %0d", exp_px.red, act_px.red);
            errors++;
          end
          if (act_px.green !== exp_px.green) begin
            $error("green_out expected %0d actual %0d", exp_px.green, act_px.green);
            errors++;
          end
          if (act_px.blue !== exp_px.blue) begin
            $error("blue_out expected %0d actual %0d", exp_px.blue, act_px.blue);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      end
    end
  end

  initial begin
    pixel_t px;
    int wait_cnt;
    errors = 0;
    sent = 0;
    received = 0;
    hold_cycles = 0;
    stall_mode = 0;
    sender_pause = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corners: black, white, greys, primaries, secondaries, hue wrap, half saturation
    pending_pixels.push_back(mk(0, 0, 0));
    pending_pixels.push_back(mk(255, 255, 255));
    pending_pixels.push_back(mk(127, 127, 127));
    pending_pixels.push_back(mk(128, 128, 128));
    pending_pixels.push_back(mk(1, 1, 1));
    pending_pixels.push_back(mk(255, 0, 0));
    pending_pixels.push_back(mk(0, 255, 0));
    pending_pixels.push_back(mk(0, 0, 255));
    pending_pixels.push_back(mk(255, 255, 0));
    pending_pixels.push_back(mk(0, 255, 255));
    pending_pixels.push_back(mk(255, 0, 255));
    pending_pixels.push_back(mk(255, 0, 1));
    pending_pixels.push_back(mk(200, 100, 150));
    pending_pixels.push_back(mk(255, 128, 128));
    pending_pixels.push_back(mk(255, 127, 127));
    pending_pixels.push_back(mk(100, 60, 80));
    pending_pixels.push_back(mk(100, 51, 50));
    pending_pixels.push_back(mk(1, 0, 0));
    pending_pixels.push_back(mk(0, 1, 2));
    pending_pixels.push_back(mk(170, 85, 255));
    for (int i = 0; i < 300; i++)
      pending_pixels.push_back(mk($urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255)));

    wait (pending_pixels.size() == 0);
    // sender waits for drain
    sender_pause = 1'b1;
    wait_cnt = 0;
    while ((in_tvalid || complement_q.size() != 0) && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    sender_pause = 1'b0;

    // long receiver hold while sender streams
    for (int i = 0; i < 300; i++) begin
      px = mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      if (i % 3 == 0) px.blue = px.red - 8'($urandom_range(0, 20));
      pending_pixels.push_back(px);
    end
    hold_cycles = 60;
    wait (pending_pixels.size() == 0);

    for (int i = 0; i < 330; i++) begin
      px = mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      if (i % 5 == 0) px = mk($urandom_range(0, 255), px.red, px.red);
      pending_pixels.push_back(px);
    end
    wait (pending_pixels.size() == 0);

    wait_cnt = 0;
    while ((in_tvalid || complement_q.size() != 0) && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (complement_q.size() != 0) begin
      $error("%0d expected results never arrived", complement_q.size());
      errors++;
    end
    $display("Sent %0d pixels, checked %0d complements (corners, greys, hue wrap,",
             sent, received);
    $display("  bursty input, random and long output stalls).");
    if (errors == 0) begin
      $display("[hsv_color_complement] OK");
    end else begin
      $display("[hsv_color_complement] ERROR");
    end
    $finish;
  end

endmodule
